// ===== hw/rtl/cnv3_pkg.sv =====
// Shared types and constants for the 3x3 multichannel convolution block.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none
package cnv3_pkg;

  localparam int DEF_MAX_WIDTH        = 64;
  localparam int DEF_MAX_HEIGHT       = 64;
  localparam int DEF_MAX_IN_CHANNELS  = 16;
  localparam int DEF_MAX_OUT_CHANNELS = 16;

  localparam int TAPS     = 9;
  localparam int TAP_W    = 4;
  localparam int SAMPLE_W = 16;
  localparam int ACC_W    = 48;

  // configuration port
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 7;
  localparam logic [CFG_IW-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_IN_CH  = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_OUT_CH = 2'd3;

  // input commands, carried in tuser
  localparam int CMD_W = 2;
  localparam logic [CMD_W-1:0] CMD_WEIGHT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PIXEL  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_IGNORE = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic wt_write;   // store weight at the load pointer
    logic px_start;   // latch pixel, restart frame if needed
    logic clr;        // write zero at the clear pointer
    logic win_shift;  // shift window, update line buffer, set up bases
    logic tap;        // issue one tap of the dot product
    logic acc_wr;     // accumulate into the store, step output channel
    logic pos_adv;    // advance pixel position
    logic rd_dummy;   // frame incomplete: return a status-only result
    logic rd_issue;   // read accumulator at the read pointer
    logic rd_out;     // load accumulator data into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic first_px;
    logic clr_last;
    logic win_ok;
    logic tap_last;
    logic och_last;
    logic frame_done;
    logic out_free;
    logic cfg_busy;   // derived sizes still settling after a config write
  } status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/cnv3_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module cnv3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== hw/rtl/cnv3_ctrl.sv =====
// Sequencer for the convolution block: accepts commands and steps the datapath.
// Depends on cnv3_pkg.
`default_nettype none
module cnv3_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  input  wire logic [cnv3_pkg::CMD_W-1:0]  in_cmd_i,
  output logic                             in_ready_o,
  input  cnv3_pkg::status_t                stat_i,
  output cnv3_pkg::cmd_t                   cmd_o
);
  import cnv3_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CLEAR = 4'd1;
  localparam logic [3:0] ST_LBRD  = 4'd2;
  localparam logic [3:0] ST_LBWR  = 4'd3;
  localparam logic [3:0] ST_TAP   = 4'd4;
  localparam logic [3:0] ST_D1    = 4'd5;
  localparam logic [3:0] ST_D2    = 4'd6;
  localparam logic [3:0] ST_ACCWR = 4'd7;
  localparam logic [3:0] ST_ADV   = 4'd8;
  localparam logic [3:0] ST_RDOUT = 4'd9;

  logic [3:0] state_q, state_d;
  logic       accept;

  // a read needs the output register to be free when its data arrives
  assign in_ready_o = (state_q == ST_IDLE) && !stat_i.cfg_busy &&
                      ((in_cmd_i != CMD_READ) || stat_i.out_free);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_cmd_i)
            CMD_WEIGHT: cmd_o.wt_write = 1'b1;
            CMD_PIXEL: begin
              cmd_o.px_start = 1'b1;
              state_d = stat_i.first_px ? ST_CLEAR : ST_LBRD;
            end
            CMD_READ: begin
              if (stat_i.frame_done) begin
                cmd_o.rd_issue = 1'b1;
                state_d = ST_RDOUT;
              end else begin
                cmd_o.rd_dummy = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (stat_i.clr_last) state_d = ST_LBRD;
      end
      ST_LBRD: state_d = ST_LBWR;
      ST_LBWR: begin
        cmd_o.win_shift = 1'b1;
        state_d = stat_i.win_ok ? ST_TAP : ST_ADV;
      end
      ST_TAP: begin
        cmd_o.tap = 1'b1;
        if (stat_i.tap_last) state_d = ST_D1;
      end
      ST_D1: state_d = ST_D2;
      ST_D2: state_d = ST_ACCWR;
      ST_ACCWR: begin
        cmd_o.acc_wr = 1'b1;
        state_d = stat_i.och_last ? ST_ADV : ST_TAP;
      end
      ST_ADV: begin
        cmd_o.pos_adv = 1'b1;
        state_d = ST_IDLE;
      end
      ST_RDOUT: begin
        cmd_o.rd_out = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/cnv3_dp.sv =====
// Datapath: configuration, weight store, line buffer, window, tap MAC,
// accumulator store and output register. Depends on cnv3_pkg and cnv3_ram.
`default_nettype none
module cnv3_dp #(
  parameter int MAX_WIDTH        = cnv3_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT       = cnv3_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_IN_CHANNELS  = cnv3_pkg::DEF_MAX_IN_CHANNELS,
  parameter int MAX_OUT_CHANNELS = cnv3_pkg::DEF_MAX_OUT_CHANNELS
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [cnv3_pkg::CFG_IW-1:0]        cfg_idx_i,
  input  wire logic [cnv3_pkg::CFG_DW-1:0]        cfg_wdata_i,
  input  wire logic signed [cnv3_pkg::SAMPLE_W-1:0] sample_i,
  input  wire logic                               out_ready_i,
  input  cnv3_pkg::cmd_t                          cmd_i,
  output cnv3_pkg::status_t                       stat_o,
  output logic                                    out_valid_o,
  output logic signed [cnv3_pkg::ACC_W-1:0]       out_value_o,
  output logic                                    out_last_o,
  output logic                                    out_status_o
);
  import cnv3_pkg::*;

  localparam int WDEPTH = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * TAPS;
  localparam int ADEPTH = MAX_OUT_CHANNELS * (MAX_WIDTH - 2) * (MAX_HEIGHT - 2);
  localparam int WAW    = $clog2(WDEPTH);
  localparam int WTW    = $clog2(WDEPTH + 1);
  localparam int AAW    = (ADEPTH > 1) ? $clog2(ADEPTH) : 1;
  localparam int ATW    = $clog2(ADEPTH + 1);
  localparam int LAW    = $clog2(MAX_WIDTH);
  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int CHW    = (MAX_IN_CHANNELS > 1) ? $clog2(MAX_IN_CHANNELS) : 1;
  localparam int OCW    = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int HW     = $clog2(MAX_HEIGHT + 1);
  localparam int ICW    = $clog2(MAX_IN_CHANNELS + 1);
  localparam int OCNW   = $clog2(MAX_OUT_CHANNELS + 1);

  // configuration and derived sizes
  logic [CFG_DW-1:0] cfg_w_q, cfg_h_q, cfg_ic_q, cfg_oc_q;
  logic [WW-1:0]     w_q, w_d;
  logic [HW-1:0]     h_q, h_d;
  logic [ICW-1:0]    ic_q, ic_d;
  logic [OCNW-1:0]   oc_q, oc_d;
  logic [WW-1:0]     ow_q;
  logic [ATW-1:0]    plane_q, rtotal_q;
  logic [WTW-1:0]    icx9_q, wtotal_q;
  logic [1:0]        settle_q;
  int unsigned       tw, th, tic, toc;

  // position and pointers
  logic [LAW-1:0] col_q;
  logic [RW-1:0]  row_q;
  logic [CHW-1:0] ch_q;
  logic           frame_done_q;
  logic           restart, first_px;
  logic [WAW-1:0] wp_q, wp_eff, wp_nx;
  logic [AAW-1:0] rp_q, rp_eff, rp_nx;
  logic           rdlast_q;
  logic [AAW-1:0] clr_q;

  // MAC
  logic signed [SAMPLE_W-1:0] px_q;
  logic signed [SAMPLE_W-1:0] win_q [TAPS];
  logic [TAP_W-1:0]           k_q, tap1_q;
  logic                       v1_q, v2_q;
  logic signed [2*SAMPLE_W-1:0] prod_q;
  logic signed [ACC_W-1:0]    dot_q;
  logic [OCW-1:0]             och_q;
  logic [WAW-1:0]             wbase_q;
  logic [AAW-1:0]             acc_addr_q;
  logic [AAW-1:0]             base_r, base_c, base_w;

  // RAM ports
  logic [SAMPLE_W-1:0]   w_rdata;
  logic [2*SAMPLE_W-1:0] lb_rdata;
  logic [ACC_W-1:0]      acc_rdata;
  logic                  acc_we;
  logic [AAW-1:0]        acc_waddr, acc_raddr;
  logic [ACC_W-1:0]      acc_wdata;

  // output register
  logic                    out_valid_q, out_last_q, out_status_q;
  logic signed [ACC_W-1:0] out_value_q;

  always_comb begin
    tw  = 32'(cfg_w_q);
    th  = 32'(cfg_h_q);
    tic = 32'(cfg_ic_q);
    toc = 32'(cfg_oc_q);
    if (tw < 3) tw = 3;
    if (tw > MAX_WIDTH) tw = MAX_WIDTH;
    if (th < 3) th = 3;
    if (th > MAX_HEIGHT) th = MAX_HEIGHT;
    if (tic < 1) tic = 1;
    if (tic > MAX_IN_CHANNELS) tic = MAX_IN_CHANNELS;
    if (toc < 1) toc = 1;
    if (toc > MAX_OUT_CHANNELS) toc = MAX_OUT_CHANNELS;
    w_d  = WW'(tw);
    h_d  = HW'(th);
    ic_d = ICW'(tic);
    oc_d = OCNW'(toc);
  end

  assign restart = (32'(col_q) >= 32'(w_q)) || (32'(row_q) >= 32'(h_q)) ||
                   (32'(ch_q) >= 32'(ic_q)) || frame_done_q;
  assign first_px = restart || ((col_q == '0) && (row_q == '0) && (ch_q == '0));

  assign wp_eff = (WTW'(wp_q) >= wtotal_q) ? '0 : wp_q;
  assign wp_nx  = (WTW'(wp_eff) + WTW'(1) >= wtotal_q) ? '0 : wp_eff + WAW'(1);
  assign rp_eff = (ATW'(rp_q) >= rtotal_q) ? '0 : rp_q;
  assign rp_nx  = (ATW'(rp_eff) + ATW'(1) >= rtotal_q) ? '0 : rp_eff + AAW'(1);

  // output position of the window's bottom-right pixel
  assign base_r = AAW'(row_q) - AAW'(2);
  assign base_c = AAW'(col_q) - AAW'(2);
  assign base_w = AAW'(ow_q);

  assign stat_o.first_px   = first_px;
  assign stat_o.clr_last   = (clr_q == AAW'(ADEPTH - 1));
  assign stat_o.win_ok     = (row_q >= RW'(2)) && (col_q >= LAW'(2));
  assign stat_o.tap_last   = (k_q == TAP_W'(TAPS - 1));
  assign stat_o.och_last   = (32'(och_q) + 1 >= 32'(oc_q));
  assign stat_o.frame_done = frame_done_q;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;
  // sizes and totals pass through three register stages after a write
  assign stat_o.cfg_busy   = cfg_we_i || (settle_q != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q      <= CFG_DW'(64);
      cfg_h_q      <= CFG_DW'(64);
      cfg_ic_q     <= CFG_DW'(1);
      cfg_oc_q     <= CFG_DW'(1);
      w_q          <= '0;
      h_q          <= '0;
      ic_q         <= '0;
      oc_q         <= '0;
      ow_q         <= '0;
      plane_q      <= '0;
      rtotal_q     <= '0;
      icx9_q       <= '0;
      wtotal_q     <= '0;
      settle_q     <= 2'd3;
      col_q        <= '0;
      row_q        <= '0;
      ch_q         <= '0;
      frame_done_q <= 1'b0;
      wp_q         <= '0;
      rp_q         <= '0;
      clr_q        <= '0;
      k_q          <= '0;
      och_q        <= '0;
      v1_q         <= 1'b0;
      v2_q         <= 1'b0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < TAPS; i++) win_q[i] <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_WIDTH:  cfg_w_q  <= cfg_wdata_i;
          CFG_HEIGHT: cfg_h_q  <= cfg_wdata_i;
          CFG_IN_CH:  cfg_ic_q <= {2'b00, cfg_wdata_i[4:0]};
          CFG_OUT_CH: cfg_oc_q <= {2'b00, cfg_wdata_i[4:0]};
          default: ;
        endcase
      end
      if (cfg_we_i) begin
        settle_q <= 2'd3;
      end else if (settle_q != 2'd0) begin
        settle_q <= settle_q - 2'd1;
      end
      w_q      <= w_d;
      h_q      <= h_d;
      ic_q     <= ic_d;
      oc_q     <= oc_d;
      ow_q     <= w_q - WW'(2);
      plane_q  <= ATW'(ATW'(w_q - WW'(2)) * ATW'(h_q - HW'(2)));
      rtotal_q <= ATW'(ATW'(oc_q) * plane_q);
      icx9_q   <= WTW'(WTW'(ic_q) * WTW'(TAPS));
      wtotal_q <= WTW'(WTW'(oc_q) * icx9_q);

      if (cmd_i.wt_write) wp_q <= wp_nx;

      if (cmd_i.px_start) begin
        if (restart) begin
          col_q <= '0;
          row_q <= '0;
          ch_q  <= '0;
        end
        if (first_px) begin
          frame_done_q <= 1'b0;
          rp_q         <= '0;
          clr_q        <= '0;
        end
      end

      if (cmd_i.clr) clr_q <= clr_q + AAW'(1);

      if (cmd_i.win_shift) begin
        for (int r = 0; r < 3; r++) begin
          win_q[r*3]   <= win_q[r*3+1];
          win_q[r*3+1] <= win_q[r*3+2];
        end
        win_q[2] <= signed'(lb_rdata[SAMPLE_W-1:0]);
        win_q[5] <= signed'(lb_rdata[2*SAMPLE_W-1:SAMPLE_W]);
        win_q[8] <= px_q;
        k_q      <= '0;
        och_q    <= '0;
      end

      v1_q <= cmd_i.tap;
      v2_q <= v1_q;
      if (cmd_i.tap) k_q <= k_q + TAP_W'(1);

      if (cmd_i.acc_wr) begin
        k_q   <= '0;
        och_q <= och_q + OCW'(1);
      end

      if (cmd_i.pos_adv) begin
        if (32'(col_q) + 1 >= 32'(w_q)) begin
          col_q <= '0;
          if (32'(row_q) + 1 >= 32'(h_q)) begin
            row_q <= '0;
            if (32'(ch_q) + 1 >= 32'(ic_q)) begin
              ch_q         <= '0;
              frame_done_q <= 1'b1;
              rp_q         <= '0;
            end else begin
              ch_q <= ch_q + CHW'(1);
            end
          end else begin
            row_q <= row_q + RW'(1);
          end
        end else begin
          col_q <= col_q + LAW'(1);
        end
      end

      if (cmd_i.rd_issue) rp_q <= rp_nx;

      if (cmd_i.rd_dummy || cmd_i.rd_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.px_start) px_q <= sample_i;
    if (cmd_i.win_shift) begin
      wbase_q    <= WAW'(ch_q) * WAW'(TAPS);
      acc_addr_q <= base_r * base_w + base_c;
      dot_q      <= '0;
    end
    tap1_q <= k_q;
    prod_q <= win_q[tap1_q] * signed'(w_rdata);
    if (v2_q) dot_q <= dot_q + ACC_W'(prod_q);
    if (cmd_i.acc_wr) begin
      dot_q      <= '0;
      wbase_q    <= wbase_q + WAW'(icx9_q);
      acc_addr_q <= acc_addr_q + AAW'(plane_q);
    end
    if (cmd_i.rd_issue) rdlast_q <= (ATW'(rp_eff) == rtotal_q - ATW'(1));
    if (cmd_i.rd_dummy) begin
      out_value_q  <= '0;
      out_last_q   <= 1'b0;
      out_status_q <= 1'b1;
    end else if (cmd_i.rd_out) begin
      out_value_q  <= signed'(acc_rdata);
      out_last_q   <= rdlast_q;
      out_status_q <= 1'b0;
    end
  end

  cnv3_ram #(.WIDTH(SAMPLE_W), .DEPTH(WDEPTH), .AW(WAW)) u_wram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wt_write),
    .waddr_i (wp_eff),
    .wdata_i (sample_i),
    .raddr_i (wbase_q + WAW'(k_q)),
    .rdata_o (w_rdata)
  );

  // both line rows in one word: upper half is the newer row
  cnv3_ram #(.WIDTH(2*SAMPLE_W), .DEPTH(MAX_WIDTH), .AW(LAW)) u_lram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.win_shift),
    .waddr_i (col_q),
    .wdata_i ({px_q, lb_rdata[2*SAMPLE_W-1:SAMPLE_W]}),
    .raddr_i (col_q),
    .rdata_o (lb_rdata)
  );

  assign acc_we    = cmd_i.clr || cmd_i.acc_wr;
  assign acc_waddr = cmd_i.clr ? clr_q : acc_addr_q;
  assign acc_wdata = cmd_i.clr ? '0 : (acc_rdata + dot_q);
  assign acc_raddr = cmd_i.rd_issue ? rp_eff : acc_addr_q;

  cnv3_ram #(.WIDTH(ACC_W), .DEPTH(ADEPTH), .AW(AAW)) u_aram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acc_waddr),
    .wdata_i (acc_wdata),
    .raddr_i (acc_raddr),
    .rdata_o (acc_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign out_value_o  = out_value_q;
  assign out_last_o   = out_last_q;
  assign out_status_o = out_status_q;

endmodule
`default_nettype wire

// ===== hw/rtl/conv3x3_stride1_multichannel.sv =====
// Top level of the 3x3 stride-1 valid convolution block.
// Depends on cnv3_pkg, cnv3_ctrl, cnv3_dp (and cnv3_ram through it).
//
// Commands arrive on the slave stream with the command code in tuser: load
// weight, push pixel, or read one accumulator. A weight load and an ignored
// code complete without leaving the idle state. A read of a finished frame
// yields one transfer on the master stream; before the frame is complete a
// read returns a status-only result. A read is held off while the output
// register is full. A pixel that closes a full 3x3 window runs nine taps per
// output channel, one multiply-accumulate a cycle through the single-port
// weight read and the one shared MAC; other pixels only shift the window and
// line buffer. The first pixel of a frame first sweeps the whole accumulator
// memory to zero, one entry a cycle: MAX_OUT_CHANNELS * (MAX_WIDTH-2) *
// (MAX_HEIGHT-2) entries (61504 at the default sizes). Configuration may be
// written at any time the block is idle; the slave stream is held off during
// a write and while the derived sizes settle after it.
`default_nettype none
module conv3x3_stride1_multichannel #(
  parameter int MAX_WIDTH        = cnv3_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT       = cnv3_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_IN_CHANNELS  = cnv3_pkg::DEF_MAX_IN_CHANNELS,
  parameter int MAX_OUT_CHANNELS = cnv3_pkg::DEF_MAX_OUT_CHANNELS
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [cnv3_pkg::CFG_IW-1:0]  cfg_idx_i,
  input  wire logic [cnv3_pkg::CFG_DW-1:0]  cfg_wdata_i,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [15:0]                  s_axis_tdata,  // [15:0] sample
  input  wire logic [1:0]                   s_axis_tuser,  // [1:0] command
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [47:0]                       m_axis_tdata,  // [47:0] out_value
  output logic                              m_axis_tlast,
  output logic [0:0]                        m_axis_tuser   // [0] status
);
  import cnv3_pkg::*;

  cmd_t                    cmd;
  status_t                 stat;
  logic signed [ACC_W-1:0] out_value;
  logic                    out_status;

  cnv3_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  cnv3_dp #(
    .MAX_WIDTH        (MAX_WIDTH),
    .MAX_HEIGHT       (MAX_HEIGHT),
    .MAX_IN_CHANNELS  (MAX_IN_CHANNELS),
    .MAX_OUT_CHANNELS (MAX_OUT_CHANNELS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .sample_i     (signed'(s_axis_tdata)),
    .out_ready_i  (m_axis_tready),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (m_axis_tvalid),
    .out_value_o  (out_value),
    .out_last_o   (m_axis_tlast),
    .out_status_o (out_status)
  );

  assign m_axis_tdata = out_value;
  assign m_axis_tuser = out_status;

endmodule
`default_nettype wire

// ===== bench/cnv3_conv_checker.sv =====
// Checker for conv3x3_stride1_multichannel: watches config writes and both streams,
// predicts each read transfer and compares it field by field. Depends on cnv3_pkg.
`timescale 1ns / 1ps
module cnv3_conv_checker
  import cnv3_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [15:0]       s_axis_tdata,
  input  logic [1:0]        s_axis_tuser,
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [47:0]       m_axis_tdata,
  input  logic              m_axis_tlast,
  input  logic [0:0]        m_axis_tuser,
  output int                fail_count_o,
  output int                pending_o
);

  typedef struct {
    logic [47:0] value;
    logic        last;
    logic        status;
  } read_beat_t;

  logic [6:0] reg_w, reg_h;
  logic [4:0] reg_ic, reg_oc;
  logic signed [15:0] kernel_mem [0:2303];
  logic signed [15:0] line_mem [0:1][0:63];
  logic signed [15:0] win [0:2][0:2];
  longint acc_mem [0:61503];
  int kptr, pos_ch, pos_row, pos_col, rd_ptr;
  bit frame_complete;
  read_beat_t expected_reads[$];
  int errors = 0;

  assign fail_count_o = errors;

  function automatic int clampi(input int v, input int lo, input int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  task automatic report(input string msg);
    $display("mismatch at %0t ns: %s", $realtime, msg);
    errors++;
  endtask

  task automatic load_kernel(input logic signed [15:0] smp);
    int total;
    total = clampi(reg_oc, 1, 16) * clampi(reg_ic, 1, 16) * TAPS;
    if (kptr >= total) kptr = 0;
    kernel_mem[kptr] = smp;
    kptr++;
    if (kptr >= total) kptr = 0;
  endtask

  task automatic push_pixel(input logic signed [15:0] px);
    int w, h, ic, oc, ow, oh, base;
    longint dot;
    w  = clampi(reg_w, 3, 64);
    h  = clampi(reg_h, 3, 64);
    ic = clampi(reg_ic, 1, 16);
    oc = clampi(reg_oc, 1, 16);
    ow = w - 2;
    oh = h - 2;
    // out-of-range position or finished frame restarts
    if (pos_col >= w || pos_row >= h || pos_ch >= ic || frame_complete) begin
      pos_col = 0; pos_row = 0; pos_ch = 0;
    end
    if (pos_col == 0 && pos_row == 0 && pos_ch == 0) begin
      foreach (acc_mem[i]) acc_mem[i] = 0;
      frame_complete = 0;
      rd_ptr = 0;
    end
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = line_mem[0][pos_col];
    win[1][2] = line_mem[1][pos_col];
    win[2][2] = px;
    line_mem[0][pos_col] = line_mem[1][pos_col];
    line_mem[1][pos_col] = px;
    if (pos_row >= 2 && pos_col >= 2) begin
      for (int o = 0; o < oc; o++) begin
        base = (o * ic + pos_ch) * TAPS;
        dot = 0;
        for (int k = 0; k < TAPS; k++)
          dot += longint'(win[k/3][k%3]) * longint'(kernel_mem[base+k]);
        acc_mem[(o * oh + pos_row - 2) * ow + pos_col - 2] += dot;
      end
    end
    pos_col++;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
      if (pos_row >= h) begin
        pos_row = 0;
        pos_ch++;
        if (pos_ch >= ic) begin
          pos_ch = 0;
          frame_complete = 1;
          rd_ptr = 0;
        end
      end
    end
  endtask

  task automatic predict_read();
    int total;
    read_beat_t b;
    total = clampi(reg_oc, 1, 16) * (clampi(reg_w, 3, 64) - 2) * (clampi(reg_h, 3, 64) - 2);
    if (!frame_complete) begin
      b.value = '0; b.last = 0; b.status = 1;
    end else begin
      if (rd_ptr >= total) rd_ptr = 0;
      b.value = acc_mem[rd_ptr][47:0];
      b.last = (rd_ptr == total - 1);
      b.status = 0;
      rd_ptr++;
      if (rd_ptr >= total) rd_ptr = 0;
    end
    expected_reads.push_back(b);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    read_beat_t b;
    if (!rst_ni) begin
      reg_w = 64; reg_h = 64; reg_ic = 1; reg_oc = 1;
      kptr = 0; pos_ch = 0; pos_row = 0; pos_col = 0; rd_ptr = 0;
      frame_complete = 0;
      foreach (win[i, j]) win[i][j] = '0;
      foreach (line_mem[i, j]) line_mem[i][j] = '0;
      expected_reads.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WIDTH:  reg_w = cfg_wdata_i;
          CFG_HEIGHT: reg_h = cfg_wdata_i;
          CFG_IN_CH:  reg_ic = cfg_wdata_i[4:0];
          CFG_OUT_CH: reg_oc = cfg_wdata_i[4:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        case (s_axis_tuser)
          CMD_WEIGHT: load_kernel(s_axis_tdata);
          CMD_PIXEL:  push_pixel(s_axis_tdata);
          CMD_READ:   predict_read();
          default: ;  // unused code, no effect
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_reads.size() == 0) begin
          report($sformatf("unexpected transfer value=%h", m_axis_tdata));
        end else begin
          b = expected_reads.pop_front();
          if (m_axis_tdata !== b.value)
            report($sformatf("value %h, want %h", m_axis_tdata, b.value));
          if (m_axis_tlast !== b.last)
            report($sformatf("tlast %b, want %b", m_axis_tlast, b.last));
          if (m_axis_tuser[0] !== b.status)
            report($sformatf("status %b, want %b", m_axis_tuser[0], b.status));
        end
      end
      pending_o = expected_reads.size();
    end
  end

endmodule

// ===== bench/tb_conv3x3_stride1_multichannel.sv =====
// Top of the testbench for conv3x3_stride1_multichannel: clock, reset, stimulus
// and verdict. Depends on cnv3_pkg, the block's RTL and cnv3_conv_checker.
`timescale 1ns / 1ps
module tb_conv3x3_stride1_multichannel;
  import cnv3_pkg::*;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CFG_IW-1:0] cfg_idx_i;
  logic [CFG_DW-1:0] cfg_wdata_i;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata;   // [15:0] sample
  logic [1:0]        s_axis_tuser;   // [1:0] command
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [47:0]       m_axis_tdata;   // [47:0] out_value
  logic              m_axis_tlast;
  logic [0:0]        m_axis_tuser;   // [0] status
  int                fail_count;
  int                pending;

  int sent = 0;
  bit calm = 0;
  bit hold_rx = 0;

  conv3x3_stride1_multichannel dut (.*);

  cnv3_conv_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #100ms;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    m_axis_tready = 0;
    @(posedge rst_ni);
    forever begin
      if (hold_rx) begin
        m_axis_tready <= 0;
        repeat (600) @(posedge clk_i);
        hold_rx = 0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1;
        @(posedge clk_i);
      end
    end
  end

  function automatic int clampi(input int v, input int lo, input int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic [1:0] cmd, input logic [15:0] smp);
    if (!calm && $urandom_range(0, 9) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= smp;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (cmd != CMD_IGNORE) sent++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic set_geometry(input int w, input int h, input int ic, input int oc);
    logic [CFG_IW-1:0] idx [4];
    int val [4];
    idx = '{CFG_WIDTH, CFG_HEIGHT, CFG_IN_CH, CFG_OUT_CH};
    val = '{w, h, ic, oc};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i <= 1;
      cfg_idx_i <= idx[i];
      cfg_wdata_i <= CFG_DW'(val[i]);
      @(posedge clk_i);
    end
    cfg_we_i <= 0;
  endtask

  // one frame: weights, pixels, then all outputs plus a few wrapped reads;
  // abort_at > 0 stops the pixels early and leaves the frame open
  task automatic run_frame(input int rw, input int rh, input int ric, input int roc,
                           input int abort_at, input bit squeeze);
    int w, h, ic, oc, npx;
    wait_idle();
    set_geometry(rw, rh, ric, roc);
    w = clampi(rw, 3, 64);
    h = clampi(rh, 3, 64);
    ic = clampi(ric & 31, 1, 16);
    oc = clampi(roc & 31, 1, 16);
    npx = w * h * ic;
    repeat (oc * ic * TAPS + $urandom_range(0, 2)) send_item(CMD_WEIGHT, rand_sample());
    if ($urandom_range(0, 2) == 0) send_item(CMD_READ, 16'($urandom));
    for (int i = 0; i < npx; i++) begin
      if (abort_at > 0 && i == abort_at) begin
        send_item(CMD_READ, 16'($urandom));
        return;
      end
      if ($urandom_range(0, 40) == 0) send_item(CMD_IGNORE, 16'($urandom));
      if (i == npx - 1 && $urandom_range(0, 3) == 0) send_item(CMD_READ, 16'($urandom));
      send_item(CMD_PIXEL, rand_sample());
    end
    if (squeeze) hold_rx = 1;
    repeat (oc * (w - 2) * (h - 2) + $urandom_range(0, 3))
      send_item(CMD_READ, 16'($urandom));
  endtask

  initial begin
    logic [15:0] kern [10];
    logic [15:0] pix [9];
    cfg_we_i = 0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    rst_ni = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: read before frame, unused code, weight wrap, extreme samples
    set_geometry(3, 3, 1, 1);
    kern = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001,
             16'h4000, 16'hc000, 16'h7fff, 16'h8000, 16'h7fff};
    pix = '{16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
            16'h8000, 16'h0000, 16'hffff, 16'h7fff};
    send_item(CMD_READ, 16'h0000);
    send_item(CMD_IGNORE, 16'hffff);
    foreach (kern[i]) send_item(CMD_WEIGHT, kern[i]);
    foreach (pix[i]) send_item(CMD_PIXEL, pix[i]);
    repeat (2) send_item(CMD_READ, 16'hffff);

    // size extremes and clamped register values
    run_frame(127, 3, 1, 1, 0, 0);
    run_frame(3, 64, 1, 1, 0, 0);
    run_frame(0, 2, 0, 31, 0, 1);
    run_frame(3, 3, 31, 1, 0, 0);
    run_frame(8, 5, 2, 2, 10, 0);
    run_frame(4, 4, 1, 2, 0, 0);   // resumes the open frame, then wraps into a new one

    while (sent < 1450) begin
      if (sent > 1200) calm = 1;
      run_frame($urandom_range(3, 8), $urandom_range(3, 6), $urandom_range(1, 3),
                $urandom_range(1, 3), 0, 0);
    end
    wait_idle();

    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
